// ----- src/sir_pkg.sv -----
// ----------------------------------------------------------------------------
// sir_pkg
// shared widths, constants and stage type for the rounded square root unit
// ----------------------------------------------------------------------------
package sir_pkg;

  localparam int RAD_W   = 32;              // radicand width
  localparam int ROOT_W  = 17;              // rounded root width
  localparam int STEPS   = RAD_W / 2;       // one cell per bit pair
  localparam int IN_TW   = 32;              // in_tdata width, whole bytes
  localparam int OUT_TW  = 24;              // out_tdata width, whole bytes

  // trial bit of the first cell, top bit pair
  localparam logic [RAD_W-1:0] TOP_BIT = RAD_W'(1) << (RAD_W - 2);

  // partial remainder and partial root handed from cell to cell
  typedef struct packed {
    logic [RAD_W-1:0] rem;
    logic [RAD_W-1:0] acc;
  } sir_stage_t;

endpackage

// ----- src/integer_sqrt_rounded_unit.sv -----
// ----------------------------------------------------------------------------
// integer_sqrt_rounded_unit
// rounded square root of a 32-bit unsigned value, 16-cell digit chain
// ----------------------------------------------------------------------------
// each transfer on the input carries one 32-bit radicand and yields exactly
// one transfer on the output carrying its square root rounded to the nearest
// integer (0 to 65536). the root is built by a chain of 16 identical cells,
// one restoring digit step per bit pair from the top pair down, followed by
// a rounding cell that adds one when the remainder exceeds the floor root and
// holds the result. 17 register stages lie between input and output. one new
// radicand can be taken every cycle while the output keeps draining, as each
// cell hands its partial remainder and root to the next. every cell has its
// own valid and stalls only when it holds an item that the cell after it
// cannot take, so a waiting result does not stop the cells behind it from
// filling up. no state survives between items.
module integer_sqrt_rounded_unit
  import sir_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,   // [31:0] radicand
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_TW-1:0] out_tdata   // [16:0] root, [23:17] zero
);

  // stage n is the input of cell n; stage STEPS feeds the rounding cell
  logic       stage_valid [STEPS+1];
  logic       stage_ready [STEPS+1];
  sir_stage_t stage_data  [STEPS+1];

  logic [ROOT_W-1:0] root;

  // first cell starts with the whole radicand as remainder and an empty root
  assign stage_valid[0]    = in_tvalid;
  assign in_tready         = stage_ready[0];
  assign stage_data[0].rem = in_tdata[RAD_W-1:0];
  assign stage_data[0].acc = '0;

  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    sir_cell #(
      .STEP (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stage_valid[g]),
      .up_ready (stage_ready[g]),
      .up_data  (stage_data[g]),
      .dn_valid (stage_valid[g+1]),
      .dn_ready (stage_ready[g+1]),
      .dn_data  (stage_data[g+1])
    );
  end

  // rounding and output register
  sir_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (stage_valid[STEPS]),
    .up_ready (stage_ready[STEPS]),
    .up_data  (stage_data[STEPS]),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_root  (root)
  );

  assign out_tdata = {(OUT_TW - ROOT_W)'(0), root};

  // rounded root never goes past 65536
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[ROOT_W-1:0] <= ROOT_W'(17'h10000)))
    else $error("root out of range");

  // padding above the root stays zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_TW-1:ROOT_W] == '0))
    else $error("out_tdata padding not zero");

  // a draining output frees the whole chain, so the input must be ready
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |-> in_tready)
    else $error("chain stalled while output drains");

  // with the last cell and the output empty, no result can appear in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (!stage_valid[STEPS] && !out_tvalid) |=> !out_tvalid)
    else $error("result without a transfer in the last cell");

endmodule

// ----- src/sir_cell.sv -----
// ----------------------------------------------------------------------------
// sir_cell
// one restoring digit step of the root chain, registered
// ----------------------------------------------------------------------------
module sir_cell
  import sir_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  sir_stage_t up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output sir_stage_t dn_data
);

  localparam logic [RAD_W-1:0] BIT_VAL = TOP_BIT >> (2 * STEP);

  logic             valid_r;
  sir_stage_t       data_r;
  sir_stage_t       data_nxt;
  logic [RAD_W-1:0] trial;
  logic [RAD_W-1:0] acc_sum;
  logic             take;

  always_comb begin
    trial    = up_data.acc + BIT_VAL;
    take     = (up_data.rem >= trial);
    acc_sum  = take ? (up_data.acc + (BIT_VAL << 1)) : up_data.acc;
    data_nxt.rem = take ? (up_data.rem - trial) : up_data.rem;
    data_nxt.acc = acc_sum >> 1;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ----- src/sir_round.sv -----
// ----------------------------------------------------------------------------
// sir_round
// final rounding and output register of the root chain
// ----------------------------------------------------------------------------
module sir_round
  import sir_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  sir_stage_t        up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output logic [ROOT_W-1:0] dn_root
);

  logic              valid_r;
  logic [ROOT_W-1:0] root_r;
  logic [ROOT_W-1:0] root_nxt;

  // round up when the remainder exceeds the floor root
  assign root_nxt = up_data.acc[ROOT_W-1:0] + ROOT_W'(up_data.rem > up_data.acc);

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      root_r <= root_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_root  = root_r;

endmodule
